// ===== rtl/core/rbv_pkg.sv =====
// Shared types, widths and rounding helpers for the rotation-between-vectors block.
package rbv_pkg;

  localparam int IN_W          = 18;
  localparam int THR_W         = 17;
  localparam int CODE_W        = 2;
  localparam int FRAC_BITS_DEF = 16;
  localparam int RND_W         = 96;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef logic signed [RND_W-1:0] wide_t;

  typedef enum logic [CODE_W-1:0] {
    CASE_GENERAL   = 2'd0,
    CASE_IDENTITY  = 2'd1,
    CASE_HALF_TURN = 2'd2
  } case_code_t;

  // shift right, round to nearest, ties away from zero
  function automatic wide_t rnd_shift(input wide_t v, input int unsigned sh);
    logic [RND_W-1:0] mag;
    mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
    mag = (mag + (RND_W'(1) << (sh - 1))) >> sh;
    return v[RND_W-1] ? wide_t'(RND_W'(0) - mag) : wide_t'(mag);
  endfunction

  function automatic logic signed [IN_W-1:0] sat_out(input wide_t v);
    if (v > wide_t'(OUT_MAX)) begin
      return IN_W'(OUT_MAX);
    end else if (v < wide_t'(OUT_MIN)) begin
      return IN_W'(OUT_MIN);
    end
    return IN_W'(v);
  endfunction

endpackage

// ===== rtl/core/rbv_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module rbv_sqrt #(
  parameter int D_W = 46,
  parameter int R_W = 23
) (
  input  logic           clk,
  input  logic           en,
  input  logic [D_W-1:0] d,
  output logic [R_W-1:0] root
);

  logic [D_W:0]   rem_r [R_W];
  logic [R_W-1:0] q_r   [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_stage
    localparam int J = R_W - 1 - k;
    logic [D_W:0]   rin;
    logic [D_W:0]   trial;
    logic [R_W-1:0] qin;

    if (k == 0) begin : g_first
      assign rin = {1'b0, d};
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign qin = q_r[k-1];
    end

    // (q + 2^J)^2 - q^2
    assign trial = ((D_W+1)'(qin) << (J + 1)) + ((D_W+1)'(1) << (2 * J));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem_r[k] <= rin - trial;
          q_r[k]   <= qin | (R_W'(1) << J);
        end else begin
          rem_r[k] <= rin;
          q_r[k]   <= qin;
        end
      end
    end
  end

  assign root = q_r[R_W-1];

endmodule

// ===== rtl/core/rbv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module rbv_div #(
  parameter int N_W = 40,
  parameter int L_W = 23,
  parameter int Q_W = 17
) (
  input  logic           clk,
  input  logic           en,
  input  logic [N_W-1:0] num,
  input  logic [L_W-1:0] den,
  output logic [Q_W-1:0] quo
);

  logic [N_W-1:0] rem_r [Q_W];
  logic [L_W-1:0] den_r [Q_W];
  logic [Q_W-1:0] q_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int J = Q_W - 1 - k;
    logic [N_W-1:0] rin;
    logic [N_W-1:0] sub;
    logic [L_W-1:0] din;
    logic [Q_W-1:0] qin;

    if (k == 0) begin : g_first
      assign rin = num;
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = q_r[k-1];
    end

    assign sub = N_W'(din) << J;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= din;
        if (rin >= sub) begin
          rem_r[k] <= rin - sub;
          q_r[k]   <= qin | (Q_W'(1) << J);
        end else begin
          rem_r[k] <= rin;
          q_r[k]   <= qin;
        end
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

// ===== rtl/core/rotation_between_unit_vectors_unit.sv =====
// Top level: rotation matrix that turns one unit vector into another.
// Takes one pair of vectors per cycle while in_ready is high and returns one 3x3 matrix per
// pair, in order. Its depth is set by the square root (one root bit per stage, R_W bits) and
// the axis divider (one quotient bit per stage). The whole pipeline moves as one: while the
// output register holds a result that is not taken, every stage holds and in_ready is low;
// nothing is lost or repeated. sine_threshold is written through cfg_wr_en / cfg_wr_data and
// should only change while the block is idle.
module rotation_between_unit_vectors_unit #(
  parameter int FRAC_BITS = rbv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [rbv_pkg::THR_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [rbv_pkg::IN_W-1:0]    from_x,
  input  logic signed [rbv_pkg::IN_W-1:0]    from_y,
  input  logic signed [rbv_pkg::IN_W-1:0]    from_z,
  input  logic signed [rbv_pkg::IN_W-1:0]    to_x,
  input  logic signed [rbv_pkg::IN_W-1:0]    to_y,
  input  logic signed [rbv_pkg::IN_W-1:0]    to_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rbv_pkg::IN_W-1:0]    m00,
  output logic signed [rbv_pkg::IN_W-1:0]    m01,
  output logic signed [rbv_pkg::IN_W-1:0]    m02,
  output logic signed [rbv_pkg::IN_W-1:0]    m10,
  output logic signed [rbv_pkg::IN_W-1:0]    m11,
  output logic signed [rbv_pkg::IN_W-1:0]    m12,
  output logic signed [rbv_pkg::IN_W-1:0]    m20,
  output logic signed [rbv_pkg::IN_W-1:0]    m21,
  output logic signed [rbv_pkg::IN_W-1:0]    m22,
  output logic [rbv_pkg::CODE_W-1:0]         case_code
);
  import rbv_pkg::*;

  // Widths follow from the field width and FRAC_BITS.
  localparam int CR_W  = 2 * IN_W + 2 - FRAC_BITS;          // cross terms and cosine
  localparam int P_W   = IN_W + 2;                          // orthogonal fallback vector
  localparam int V_W   = (CR_W > P_W) ? CR_W : P_W;         // vector being normalised
  localparam int SQ_W  = 2 * V_W;
  localparam int D_W   = 2 * V_W + 2;                       // sum of squares
  localparam int R_W   = V_W + 1;                           // vector length
  localparam int C_W   = (CR_W > FRAC_BITS + 2) ? CR_W : FRAC_BITS + 2;
  localparam int A_W   = FRAC_BITS + 2;                     // unit axis component
  localparam int ICO_W = C_W + 1;                           // 1 - cos
  localparam int Q_W   = FRAC_BITS + 1;                     // axis magnitude
  localparam int N_W   = R_W + Q_W;                         // divider numerator
  localparam int S_W   = R_W + 1;
  localparam int SP_W  = A_W + S_W;
  localparam int SS_W  = SP_W - FRAC_BITS + 1;
  localparam int AP_W  = 2 * A_W;
  localparam int NP_W  = A_W + ICO_W;
  localparam int PR_W  = 2 * IN_W;
  localparam int CMP_W = (R_W > THR_W) ? R_W : THR_W;
  localparam int LAT   = 4 + R_W + 1 + Q_W + 1 + 4;

  localparam logic signed [C_W-1:0]  NEG_ONE = C_W'(0) - (C_W'(1) << FRAC_BITS);
  localparam logic signed [IN_W-1:0] ONE_SAT = sat_out(wide_t'(1) <<< FRAC_BITS);

  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  typedef struct packed {
    logic [2:0][CR_W-1:0] cr;
    logic [CR_W-1:0]      c;
    logic [2:0][P_W-1:0]  p;
  } vec_side_t;

  typedef struct packed {
    logic [2:0]     neg;
    logic [R_W-1:0] s;
    logic [C_W-1:0] cc;
    case_code_t     code;
    logic           zero;
  } axis_side_t;

  // ---------------- control ----------------
  logic [THR_W-1:0] sine_threshold;
  logic [LAT-1:0]   vld;
  logic             en;

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_threshold <= THR_RESET;
    end else if (cfg_wr_en) begin
      sine_threshold <= cfg_wr_data;
    end
  end

  // every stage advances together unless the result in the output register is held
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: all nine from*to products ----------------
  logic signed [IN_W-1:0] ain [3];
  logic signed [IN_W-1:0] bin [3];
  logic signed [IN_W-1:0] a1  [3];
  logic signed [PR_W-1:0] pr  [9];

  assign ain[0] = from_x;
  assign ain[1] = from_y;
  assign ain[2] = from_z;
  assign bin[0] = to_x;
  assign bin[1] = to_y;
  assign bin[2] = to_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= ain[i];
        for (int j = 0; j < 3; j++) begin
          pr[3*i+j] <= ain[i] * bin[j];
        end
      end
    end
  end

  // ---------------- stage 2: cross, dot, fallback vector ----------------
  logic signed [CR_W-1:0] cr2 [3];
  logic signed [CR_W-1:0] c2;
  logic signed [P_W-1:0]  p2  [3];
  wide_t                  cx [3];
  wide_t                  dot;
  wide_t                  pv [3];
  logic [IN_W:0]          absa [3];
  axis_t                  dom;

  always_comb begin
    cx[0] = wide_t'(pr[5]) - wide_t'(pr[7]);
    cx[1] = wide_t'(pr[6]) - wide_t'(pr[2]);
    cx[2] = wide_t'(pr[1]) - wide_t'(pr[3]);
    dot   = wide_t'(pr[0]) + wide_t'(pr[4]) + wide_t'(pr[8]);
    for (int i = 0; i < 3; i++) begin
      absa[i] = a1[i][IN_W-1] ? (IN_W+1)'(0) - (IN_W+1)'(a1[i]) : (IN_W+1)'(a1[i]);
    end
    // later axis wins ties: x needs a strict win over y and z, y a strict win over z
    if (absa[0] > absa[1]) begin
      dom = (absa[0] > absa[2]) ? AXIS_X : AXIS_Z;
    end else begin
      dom = (absa[1] > absa[2]) ? AXIS_Y : AXIS_Z;
    end
    case (dom)
      AXIS_X: begin
        pv[0] = -wide_t'(a1[1]) - wide_t'(a1[2]);
        pv[1] = wide_t'(a1[0]);
        pv[2] = wide_t'(a1[0]);
      end
      AXIS_Y: begin
        pv[0] = wide_t'(a1[1]);
        pv[1] = -wide_t'(a1[0]) - wide_t'(a1[2]);
        pv[2] = wide_t'(a1[1]);
      end
      default: begin
        pv[0] = wide_t'(a1[2]);
        pv[1] = wide_t'(a1[2]);
        pv[2] = -wide_t'(a1[0]) - wide_t'(a1[1]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cr2[i] <= CR_W'(rnd_shift(cx[i], FRAC_BITS));
        p2[i]  <= P_W'(pv[i]);
      end
      c2 <= CR_W'(rnd_shift(dot, FRAC_BITS));
    end
  end

  // ---------------- stage 3: squares ----------------
  logic signed [V_W-1:0]  vc [3];
  logic signed [V_W-1:0]  vp [3];
  logic signed [SQ_W-1:0] sq_c [3];
  logic signed [SQ_W-1:0] sq_p [3];
  vec_side_t              side3;
  vec_side_t              side4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vc[i] = V_W'(cr2[i]);
      vp[i] = V_W'(p2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_c[i]     <= vc[i] * vc[i];
        sq_p[i]     <= vp[i] * vp[i];
        side3.cr[i] <= cr2[i];
        side3.p[i]  <= p2[i];
      end
      side3.c <= c2;
    end
  end

  // ---------------- stage 4: sums of squares ----------------
  logic [D_W-1:0] dc;
  logic [D_W-1:0] dp;

  always_ff @(posedge clk) begin
    if (en) begin
      dc    <= D_W'(sq_c[0]) + D_W'(sq_c[1]) + D_W'(sq_c[2]);
      dp    <= D_W'(sq_p[0]) + D_W'(sq_p[1]) + D_W'(sq_p[2]);
      side4 <= side3;
    end
  end

  // ---------------- square roots: length of both candidate vectors ----------------
  logic [R_W-1:0] len_c;
  logic [R_W-1:0] len_p;
  vec_side_t      sdl [R_W];

  rbv_sqrt #(.D_W(D_W), .R_W(R_W)) u_sqrt_cross (
    .clk (clk), .en (en), .d (dc), .root (len_c)
  );

  rbv_sqrt #(.D_W(D_W), .R_W(R_W)) u_sqrt_orth (
    .clk (clk), .en (en), .d (dp), .root (len_p)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sdl[0] <= side4;
      for (int i = 1; i < R_W; i++) begin
        sdl[i] <= sdl[i-1];
      end
    end
  end

  // ---------------- stage 5: case decision, divider operands ----------------
  vec_side_t              vs;
  logic                   colin;
  logic                   cpos;
  logic                   half;
  logic signed [V_W-1:0]  vsel [3];
  logic [V_W-1:0]         vmag [3];
  logic [R_W-1:0]         len_sel;
  logic [N_W-1:0]         num5 [3];
  logic [R_W-1:0]         len5;
  axis_side_t             as5;
  axis_side_t             ddl [Q_W];

  always_comb begin
    vs      = sdl[R_W-1];
    colin   = CMP_W'(len_c) <= CMP_W'(sine_threshold);
    cpos    = $signed(vs.c) > 0;
    half    = colin && !cpos;
    len_sel = half ? len_p : len_c;
    for (int i = 0; i < 3; i++) begin
      vsel[i] = half ? V_W'($signed(vs.p[i])) : V_W'($signed(vs.cr[i]));
      vmag[i] = vsel[i][V_W-1] ? V_W'(0) - V_W'(vsel[i]) : V_W'(vsel[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num5[i]   <= (N_W'(vmag[i]) << FRAC_BITS) + N_W'(len_sel >> 1);
        as5.neg[i] <= vsel[i][V_W-1];
      end
      len5    <= len_sel;
      as5.s    <= half ? '0 : len_c;
      as5.cc   <= half ? NEG_ONE : C_W'($signed(vs.c));
      as5.zero <= (len_sel == '0);
      if (colin && cpos) begin
        as5.code <= CASE_IDENTITY;
      end else if (half) begin
        as5.code <= CASE_HALF_TURN;
      end else begin
        as5.code <= CASE_GENERAL;
      end
    end
  end

  // ---------------- dividers: unit axis ----------------
  logic [Q_W-1:0] quo [3];

  for (genvar g = 0; g < 3; g++) begin : g_div
    rbv_div #(.N_W(N_W), .L_W(R_W), .Q_W(Q_W)) u_div (
      .clk (clk), .en (en), .num (num5[g]), .den (len5), .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ddl[0] <= as5;
      for (int i = 1; i < Q_W; i++) begin
        ddl[i] <= ddl[i-1];
      end
    end
  end

  // ---------------- stage 6: signed axis ----------------
  axis_side_t            as6;
  logic signed [A_W-1:0] axis6 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      as6 <= ddl[Q_W-1];
      for (int i = 0; i < 3; i++) begin
        if (ddl[Q_W-1].zero) begin
          axis6[i] <= '0;
        end else if (ddl[Q_W-1].neg[i]) begin
          axis6[i] <= A_W'(0) - A_W'(quo[i]);
        end else begin
          axis6[i] <= A_W'(quo[i]);
        end
      end
    end
  end

  // ---------------- matrix stage 1: axis products, sine products, 1 - cos ----------------
  logic signed [AP_W-1:0]  pa [6];
  logic signed [SP_W-1:0]  ps [3];
  logic signed [ICO_W-1:0] ico1;
  logic signed [S_W-1:0]   s6;
  logic [C_W-1:0]          cc1;
  case_code_t              code1;

  assign s6 = $signed({1'b0, as6.s});

  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= axis6[0] * axis6[0];
      pa[1] <= axis6[0] * axis6[1];
      pa[2] <= axis6[0] * axis6[2];
      pa[3] <= axis6[1] * axis6[1];
      pa[4] <= axis6[1] * axis6[2];
      pa[5] <= axis6[2] * axis6[2];
      for (int i = 0; i < 3; i++) begin
        ps[i] <= axis6[i] * s6;
      end
      ico1  <= (ICO_W'(1) << FRAC_BITS) - ICO_W'($signed(as6.cc));
      cc1   <= as6.cc;
      code1 <= as6.code;
    end
  end

  // ---------------- matrix stage 2: rounding ----------------
  logic signed [A_W-1:0]   aa [6];
  logic signed [SS_W-1:0]  ss2 [3];
  logic signed [ICO_W-1:0] ico2;
  logic [C_W-1:0]          cc2;
  case_code_t              code2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        aa[i] <= A_W'(rnd_shift(wide_t'(pa[i]), FRAC_BITS));
      end
      for (int i = 0; i < 3; i++) begin
        ss2[i] <= SS_W'(rnd_shift(wide_t'(ps[i]), FRAC_BITS));
      end
      ico2  <= ico1;
      cc2   <= cc1;
      code2 <= code1;
    end
  end

  // ---------------- matrix stage 3: times (1 - cos) ----------------
  logic signed [NP_W-1:0] np3 [6];
  logic signed [SS_W-1:0] ss3 [3];
  logic [C_W-1:0]         cc3;
  case_code_t             code3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        np3[i] <= aa[i] * ico2;
      end
      ss3   <= ss2;
      cc3   <= cc2;
      code3 <= code2;
    end
  end

  // ---------------- matrix stage 4: sums, saturation, output register ----------------
  wide_t nn [6];
  wide_t sw [3];
  wide_t cw;
  logic signed [IN_W-1:0] mel [9];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      nn[i] = rnd_shift(wide_t'(np3[i]), FRAC_BITS);
    end
    for (int i = 0; i < 3; i++) begin
      sw[i] = wide_t'(ss3[i]);
    end
    cw = wide_t'($signed(cc3));
    if (code3 == CASE_IDENTITY) begin
      for (int i = 0; i < 9; i++) begin
        mel[i] = '0;
      end
      mel[0] = ONE_SAT;
      mel[4] = ONE_SAT;
      mel[8] = ONE_SAT;
    end else begin
      mel[0] = sat_out(nn[0] + cw);
      mel[1] = sat_out(nn[1] + sw[2]);
      mel[2] = sat_out(nn[2] - sw[1]);
      mel[3] = sat_out(nn[1] - sw[2]);
      mel[4] = sat_out(nn[3] + cw);
      mel[5] = sat_out(nn[4] + sw[0]);
      mel[6] = sat_out(nn[2] + sw[1]);
      mel[7] = sat_out(nn[4] - sw[0]);
      mel[8] = sat_out(nn[5] + cw);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m00       <= mel[0];
      m01       <= mel[1];
      m02       <= mel[2];
      m10       <= mel[3];
      m11       <= mel[4];
      m12       <= mel[5];
      m20       <= mel[6];
      m21       <= mel[7];
      m22       <= mel[8];
      case_code <= code3;
    end
  end

endmodule
